// ===== sv/bbs_pkg.sv =====
// Shared constants, codes and types for the button and battery supervisor.
package bbs_pkg;

  // Number of debounced buttons.
  localparam int NUM_BUTTONS = 3;

  // Field and state widths.
  localparam int SAMPLE_W   = 12;
  localparam int MV_W       = 14;
  localparam int TICK_W     = 32;
  localparam int CNT_W      = 9;
  localparam int BLINK_W    = 10;
  localparam int SETTLE_W   = 8;
  localparam int STEP_W     = 4;
  localparam int EVENT_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int PROD_W     = SAMPLE_W + MV_W;

  // Millivolt scaling: sample * MV_SCALE / ADC_FULL_SCALE.
  localparam int MV_SCALE       = 11000;
  localparam int ADC_FULL_SCALE = 4095;

  // Button event codes.
  localparam logic [EVENT_W-1:0] EV_NONE     = 2'd0;
  localparam logic [EVENT_W-1:0] EV_PRESSED  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_RELEASED = 2'd2;
  localparam logic [EVENT_W-1:0] EV_REPEAT   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_BATTERY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_SETTLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_SETTLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_RELOAD  = 3'd4;

  // Configuration reset values.
  localparam logic [MV_W-1:0]     RST_LOW_BATTERY   = 14'd3400;
  localparam logic [SETTLE_W-1:0] RST_CHARGE_SETTLE = 8'd200;
  localparam logic [SETTLE_W-1:0] RST_BUTTON_SETTLE = 8'd20;
  localparam logic [STEP_W-1:0]   RST_COUNT_STEP    = 4'd5;
  localparam logic [BLINK_W-1:0]  RST_BLINK_RELOAD  = 10'd100;

  // Configuration register set.
  typedef struct packed {
    logic [MV_W-1:0]     low_battery_mv;
    logic [SETTLE_W-1:0] charge_settle;
    logic [SETTLE_W-1:0] button_settle;
    logic [STEP_W-1:0]   count_step;
    logic [BLINK_W-1:0]  blink_reload;
  } cfg_t;

endpackage

// ===== sv/button_and_battery_supervisor_unit.sv =====
// Top level of the button and battery supervisor: input stage, update logic, result stage.
//
//   Channel  Handshake              Carries
//   in       in_valid / in_stall    ADC samples, charger pin, three button pins
//   out      out_valid / out_stall  tick count, millivolts, LED level, button events
//   cfg      cfg_valid / cfg_ready  register index and write data
//
// A request is registered in the input register on acceptance; its result is then
// registered in the output register, where out_valid marks it.
// One request is taken every cycle while the output side does not stall.
// All state (tick count, debounce counters, blink timer) updates in the
// cycle a request moves from the input register into the output register.
// A stalled output holds its result; the input register keeps one more request.
// Synchronous reset clears all control state and loads the register defaults.
module button_and_battery_supervisor_unit
  import bbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   bus_sample,
  input  logic [SAMPLE_W-1:0]   battery_sample,
  input  logic                  charge_pin,
  input  logic                  button0_pin,
  input  logic                  button1_pin,
  input  logic                  button2_pin,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TICK_W-1:0]     tick_number,
  output logic [MV_W-1:0]       bus_millivolts,
  output logic [MV_W-1:0]       battery_millivolts,
  output logic                  charge_led_level,
  output logic [EVENT_W-1:0]    button0_event,
  output logic [EVENT_W-1:0]    button1_event,
  output logic [EVENT_W-1:0]    button2_event,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                    cfg;
  logic                    s1_valid;
  logic [SAMPLE_W-1:0]     s1_bus;
  logic [SAMPLE_W-1:0]     s1_battery;
  logic                    s1_charge;
  logic [NUM_BUTTONS-1:0]  s1_buttons;
  logic [NUM_BUTTONS-1:0]  in_buttons;
  logic                    out_move;
  logic                    fire;
  logic [TICK_W-1:0]       tick_total;
  logic [TICK_W-1:0]       tick_next;
  logic [MV_W-1:0]         bus_mv;
  logic [MV_W-1:0]         battery_mv;
  logic                    led;
  logic [EVENT_W-1:0]      events [NUM_BUTTONS];
  logic [EVENT_W-1:0]      out_events [NUM_BUTTONS];

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_battery_mv <= RST_LOW_BATTERY;
      cfg.charge_settle  <= RST_CHARGE_SETTLE;
      cfg.button_settle  <= RST_BUTTON_SETTLE;
      cfg.count_step     <= RST_COUNT_STEP;
      cfg.blink_reload   <= RST_BLINK_RELOAD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOW_BATTERY:   cfg.low_battery_mv <= cfg_data[MV_W-1:0];
        CFG_CHARGE_SETTLE: cfg.charge_settle  <= cfg_data[SETTLE_W-1:0];
        CFG_BUTTON_SETTLE: cfg.button_settle  <= cfg_data[SETTLE_W-1:0];
        CFG_COUNT_STEP:    cfg.count_step     <= cfg_data[STEP_W-1:0];
        CFG_BLINK_RELOAD:  cfg.blink_reload   <= cfg_data[BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the output register frees up when empty or taken this cycle.
  assign out_move = !out_valid || !out_stall;
  assign fire     = s1_valid && out_move;
  assign in_stall = s1_valid && !out_move;

  assign in_buttons[0] = button0_pin;
  assign in_buttons[1] = button1_pin;
  assign in_buttons[2] = button2_pin;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_bus     <= bus_sample;
      s1_battery <= battery_sample;
      s1_charge  <= charge_pin;
      s1_buttons <= in_buttons;
    end
  end

  // Tick count, advanced once per processed request.
  assign tick_next = tick_total + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_total <= '0;
    end else if (fire) begin
      tick_total <= tick_next;
    end
  end

  // Sample conversion.
  bbs_mv_conv u_bus_conv (
    .sample (s1_bus),
    .mv     (bus_mv)
  );

  bbs_mv_conv u_battery_conv (
    .sample (s1_battery),
    .mv     (battery_mv)
  );

  // Charge LED control.
  bbs_charge_led u_charge_led (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .pin        (s1_charge),
    .battery_mv (battery_mv),
    .cfg        (cfg),
    .led        (led)
  );

  // One debouncer per button.
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_button
    bbs_button u_button (
      .clk        (clk),
      .rst        (rst),
      .fire       (fire),
      .pin        (s1_buttons[b]),
      .settle     (cfg.button_settle),
      .step       (cfg.count_step),
      .event_code (events[b])
    );
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tick_number        <= tick_next;
      bus_millivolts     <= bus_mv;
      battery_millivolts <= battery_mv;
      charge_led_level   <= led;
      out_events         <= events;
    end
  end

  assign button0_event = out_events[0];
  assign button1_event = out_events[1];
  assign button2_event = out_events[2];

  // The input side only stalls while a request is parked in the input register.
  a_stall_needs_parked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

  // The tick count moves by exactly one per processed request.
  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    fire |=> tick_total == $past(tick_total) + 1'b1)
    else $error("tick count did not advance by one");

  a_tick_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(tick_total))
    else $error("tick count changed without a request");

  // Converted voltages never exceed full scale.
  a_mv_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bus_millivolts <= MV_W'(MV_SCALE)) &&
                  (battery_millivolts <= MV_W'(MV_SCALE)))
    else $error("millivolt result above full scale");

  // A result carries the tick count that was just reached.
  a_result_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tick_number == tick_total)
    else $error("result tick number disagrees with tick count");

endmodule

// ===== sv/bbs_mv_conv.sv =====
// Converts one raw ADC sample to millivolts: sample * 11000 / 4095, truncated.
module bbs_mv_conv
  import bbs_pkg::*;
(
  input  logic [SAMPLE_W-1:0] sample,
  output logic [MV_W-1:0]     mv
);

  logic [PROD_W-1:0] prod;
  logic [MV_W-1:0]   q0;
  logic [MV_W:0]     r0;
  logic [2:0]        q1;
  logic [12:0]       r1;
  logic              adj;

  // Scale the sample up; the product fits in 26 bits.
  assign prod = PROD_W'(sample) * PROD_W'(MV_SCALE);

  // Divide by 4095 as a divide by 4096 plus folded remainders:
  // x = 4096*q + lo = 4095*q + (q + lo), applied twice, then one compare.
  assign q0  = prod[PROD_W-1:12];
  assign r0  = (MV_W+1)'(prod[11:0]) + (MV_W+1)'(q0);
  assign q1  = r0[MV_W:12];
  assign r1  = 13'(r0[11:0]) + 13'(q1);
  assign adj = (r1 >= 13'(ADC_FULL_SCALE));

  assign mv = q0 + MV_W'(q1) + MV_W'(adj);

endmodule

// ===== sv/bbs_button.sv =====
// Debounce and event generation for one active-low button.
module bbs_button
  import bbs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic                pin,
  input  logic [SETTLE_W-1:0] settle,
  input  logic [STEP_W-1:0]   step,
  output logic [EVENT_W-1:0]  event_code
);

  logic             seen;
  logic             seen_next;
  logic             stable;
  logic             stable_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Settle counting, then a press or release once, then repeats while held.
  always_comb begin
    seen_next   = seen;
    stable_next = stable;
    count_next  = count;
    event_code  = EV_NONE;
    if (pin == seen) begin
      if (count < CNT_W'(settle)) begin
        count_next = count + CNT_W'(step);
      end else if (stable != seen) begin
        event_code  = seen ? EV_RELEASED : EV_PRESSED;
        stable_next = seen;
      end else if (!seen) begin
        event_code = EV_REPEAT;
      end
    end else begin
      seen_next  = pin;
      count_next = '0;
    end
  end

  // State advances only when a request is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen   <= 1'b0;
      stable <= 1'b0;
      count  <= '0;
    end else if (fire) begin
      seen   <= seen_next;
      stable <= stable_next;
      count  <= count_next;
    end
  end

endmodule

// ===== sv/bbs_charge_led.sv =====
// Charger pin debounce and charge LED control with low-battery blinking.
module bbs_charge_led
  import bbs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic            pin,
  input  logic [MV_W-1:0] battery_mv,
  input  cfg_t            cfg,
  output logic            led
);

  logic               seen;
  logic               seen_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [BLINK_W-1:0] blink;
  logic [BLINK_W-1:0] blink_next;
  logic               led_level;
  logic               led_next;

  // Once the pin has settled: dark while not charging; while charging, blink on a low battery, else lit.
  always_comb begin
    seen_next  = seen;
    count_next = count;
    blink_next = blink;
    led_next   = led_level;
    if (pin == seen) begin
      if (count < CNT_W'(cfg.charge_settle)) begin
        count_next = count + CNT_W'(cfg.count_step);
      end else if (!pin) begin
        led_next = 1'b0;
      end else if (battery_mv < cfg.low_battery_mv) begin
        if (blink != '0) begin
          blink_next = blink - 1'b1;
        end else begin
          blink_next = cfg.blink_reload;
          led_next   = ~led_level;
        end
      end else begin
        blink_next = cfg.blink_reload;
        led_next   = 1'b1;
      end
    end else begin
      seen_next  = pin;
      count_next = '0;
    end
  end

  // The result carries the level after this tick's update.
  assign led = led_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= 1'b0;
      count     <= '0;
      blink     <= '0;
      led_level <= 1'b1;
    end else if (fire) begin
      seen      <= seen_next;
      count     <= count_next;
      blink     <= blink_next;
      led_level <= led_next;
    end
  end

endmodule

// ===== verif/supervisor_checker.sv =====
// Checker for the button and battery supervisor: tracks its state, predicts each tick, compares results.
`timescale 1ns / 100ps
module supervisor_checker
  import bbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   bus_sample,
  input  logic [SAMPLE_W-1:0]   battery_sample,
  input  logic                  charge_pin,
  input  logic                  button0_pin,
  input  logic                  button1_pin,
  input  logic                  button2_pin,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [TICK_W-1:0]     tick_number,
  input  logic [MV_W-1:0]       bus_millivolts,
  input  logic [MV_W-1:0]       battery_millivolts,
  input  logic                  charge_led_level,
  input  logic [EVENT_W-1:0]    button0_event,
  input  logic [EVENT_W-1:0]    button1_event,
  input  logic [EVENT_W-1:0]    button2_event,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic [TICK_W-1:0]                    tick;
    logic [MV_W-1:0]                      bus_mv;
    logic [MV_W-1:0]                      bat_mv;
    logic                                 led;
    logic [NUM_BUTTONS-1:0][EVENT_W-1:0]  events;
  } tick_result_t;

  // Mirror of the register set and of the supervisor state.
  cfg_t                 regs;
  logic [TICK_W-1:0]    tick_total;
  logic                 charge_seen;
  logic [CNT_W-1:0]     charge_count;
  logic [BLINK_W-1:0]   blink_count;
  logic                 led_level;
  logic [NUM_BUTTONS-1:0] btn_seen;
  logic [NUM_BUTTONS-1:0] btn_stable;
  logic [CNT_W-1:0]     btn_count [NUM_BUTTONS];

  tick_result_t expected_ticks [$];
  int err_count = 0;

  assign mismatches = err_count;

  function automatic logic [MV_W-1:0] sample_to_mv(logic [SAMPLE_W-1:0] s);
    int unsigned mv;
    mv = (int'(s) * MV_SCALE) / ADC_FULL_SCALE;
    return mv[MV_W-1:0];
  endfunction

  // Advance the supervisor by one tick and return the result it reports.
  task automatic advance_supervisor(input logic [SAMPLE_W-1:0] bus,
                                    input logic [SAMPLE_W-1:0] bat,
                                    input logic chg,
                                    input logic [NUM_BUTTONS-1:0] pins,
                                    output tick_result_t r);
    logic [MV_W-1:0]    bat_mv;
    logic [EVENT_W-1:0] ev;
    tick_total = tick_total + 1'b1;
    bat_mv = sample_to_mv(bat);
    r.tick = tick_total;
    r.bus_mv = sample_to_mv(bus);
    r.bat_mv = bat_mv;

    // Charger pin debounce and LED drive.
    if (chg == charge_seen) begin
      if (charge_count < CNT_W'(regs.charge_settle)) begin
        charge_count = charge_count + CNT_W'(regs.count_step);
      end else if (!chg) begin
        led_level = 1'b0;
      end else if (bat_mv < regs.low_battery_mv) begin
        if (blink_count != '0) begin
          blink_count = blink_count - 1'b1;
        end else begin
          blink_count = regs.blink_reload;
          led_level = ~led_level;
        end
      end else begin
        blink_count = regs.blink_reload;
        led_level = 1'b1;
      end
    end else begin
      charge_seen = chg;
      charge_count = '0;
    end

    // Button debounce and event selection.
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      ev = EV_NONE;
      if (pins[b] == btn_seen[b]) begin
        if (btn_count[b] < CNT_W'(regs.button_settle)) begin
          btn_count[b] = btn_count[b] + CNT_W'(regs.count_step);
        end else if (btn_stable[b] != btn_seen[b]) begin
          ev = btn_seen[b] ? EV_RELEASED : EV_PRESSED;
          btn_stable[b] = btn_seen[b];
        end else if (!btn_seen[b]) begin
          ev = EV_REPEAT;
        end
      end else begin
        btn_seen[b] = pins[b];
        btn_count[b] = '0;
      end
      r.events[b] = ev;
    end
    r.led = led_level;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    tick_result_t fresh;
    logic [NUM_BUTTONS-1:0][EVENT_W-1:0] got_events;
    if (rst) begin
      regs.low_battery_mv = RST_LOW_BATTERY;
      regs.charge_settle = RST_CHARGE_SETTLE;
      regs.button_settle = RST_BUTTON_SETTLE;
      regs.count_step = RST_COUNT_STEP;
      regs.blink_reload = RST_BLINK_RELOAD;
      tick_total = '0;
      charge_seen = 1'b0;
      charge_count = '0;
      blink_count = '0;
      led_level = 1'b1;
      btn_seen = '0;
      btn_stable = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) btn_count[b] = '0;
      expected_ticks.delete();
    end else begin
      // The user must make register writes only while the block is idle; this checker does not enforce it.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LOW_BATTERY:   regs.low_battery_mv = cfg_data[MV_W-1:0];
          CFG_CHARGE_SETTLE: regs.charge_settle = cfg_data[SETTLE_W-1:0];
          CFG_BUTTON_SETTLE: regs.button_settle = cfg_data[SETTLE_W-1:0];
          CFG_COUNT_STEP:    regs.count_step = cfg_data[STEP_W-1:0];
          CFG_BLINK_RELOAD:  regs.blink_reload = cfg_data[BLINK_W-1:0];
          default: ;
        endcase
      end

      // Compare each delivered result with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (expected_ticks.size() == 0) begin
          $display("%0t: result tick %0d arrived with no request pending",
                   $time, tick_number);
          err_count++;
        end else begin
          want = expected_ticks.pop_front();
          got_events = {button2_event, button1_event, button0_event};
          compare_field("tick_number", want.tick, tick_number);
          compare_field("bus_millivolts", want.bus_mv, bus_millivolts);
          compare_field("battery_millivolts", want.bat_mv, battery_millivolts);
          compare_field("charge_led_level", want.led, charge_led_level);
          for (int b = 0; b < NUM_BUTTONS; b++) begin
            compare_field($sformatf("button%0d_event", b), want.events[b],
                          got_events[b]);
          end
        end
      end

      // Predict the result of each accepted request.
      if (in_valid && !in_stall) begin
        advance_supervisor(bus_sample, battery_sample, charge_pin,
                           {button2_pin, button1_pin, button0_pin}, fresh);
        expected_ticks.push_back(fresh);
      end
    end
    outstanding <= expected_ticks.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the supervisor testbench: clock, reset, request stimulus, register programming, verdict.
`timescale 1ns / 100ps
module testbench;
  import bbs_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   bus_sample = '0;
  logic [SAMPLE_W-1:0]   battery_sample = '0;
  logic                  charge_pin = 1'b0;
  logic                  button0_pin = 1'b0;
  logic                  button1_pin = 1'b0;
  logic                  button2_pin = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [TICK_W-1:0]     tick_number;
  logic [MV_W-1:0]       bus_millivolts;
  logic [MV_W-1:0]       battery_millivolts;
  logic                  charge_led_level;
  logic [EVENT_W-1:0]    button0_event;
  logic [EVENT_W-1:0]    button1_event;
  logic [EVENT_W-1:0]    button2_event;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    outstanding;

  // Current register values, used to shape pin hold times.
  int cur_low = int'(RST_LOW_BATTERY);
  int cur_cs = int'(RST_CHARGE_SETTLE);
  int cur_bs = int'(RST_BUTTON_SETTLE);
  int cur_step = int'(RST_COUNT_STEP);

  // Pin generator state: line 0 is the charger, lines 1.. are the buttons.
  logic [NUM_BUTTONS:0] line_level = '0;
  int line_hold [NUM_BUTTONS+1];
  int bat_base = 0;
  int bat_hold = 0;
  int burst_left = 0;
  int cycle_count = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_left = 0;

  button_and_battery_supervisor_unit dut (.*);
  supervisor_checker checker_i (.*);

  always #5 clk = ~clk;

  // Receiver stall pattern, with a new mode picked at random whenever the current one runs out.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(5, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= stall_left[2];
      default:        out_stall <= 1'b0;
    endcase
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one request, opening a new burst after a random gap when needed.
  task send_tick(input logic [SAMPLE_W-1:0] bus, input logic [SAMPLE_W-1:0] bat,
                 input logic chg, input logic [NUM_BUTTONS-1:0] btn);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    bus_sample <= bus;
    battery_sample <= bat;
    charge_pin <= chg;
    {button2_pin, button1_pin, button0_pin} <= btn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has been delivered.
  task drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Narrow registers sometimes get junk in the bits above their width.
  function automatic logic [CFG_DATA_W-1:0] widen(int value, int width);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    if ($urandom_range(0, 1)) return CFG_DATA_W'(value | (int'(noise) << width));
    return CFG_DATA_W'(value);
  endfunction

  task program_registers(input int low, input int cs, input int bs, input int step,
                         input int blink);
    cur_low = low;
    cur_cs = cs;
    cur_bs = bs;
    cur_step = step;
    cfg_write(CFG_LOW_BATTERY, CFG_DATA_W'(low));
    cfg_write(CFG_CHARGE_SETTLE, widen(cs, SETTLE_W));
    cfg_write(CFG_BUTTON_SETTLE, widen(bs, SETTLE_W));
    cfg_write(CFG_COUNT_STEP, widen(step, STEP_W));
    cfg_write(CFG_BLINK_RELOAD, widen(blink, BLINK_W));
    // An index past the last register must be ignored.
    cfg_write(CFG_IDX_W'(int'(CFG_BLINK_RELOAD) + 1 + $urandom_range(0, 2)),
              CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Ticks a pin must hold to settle under the current registers.
  function automatic int settle_span(int settle);
    if (cur_step == 0) return (settle == 0) ? 1 : $urandom_range(2, 12);
    return (settle + cur_step - 1) / cur_step + 1;
  endfunction

  // Mostly pins that hold long enough to settle, with glitches mixed in.
  task random_tick();
    int need;
    int roll;
    int mv;
    logic [SAMPLE_W-1:0] bus;
    logic [SAMPLE_W-1:0] bat;
    for (int i = 0; i <= NUM_BUTTONS; i++) begin
      if (line_hold[i] <= 0) begin
        need = settle_span((i == 0) ? cur_cs : cur_bs);
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
          line_level[i] = ~line_level[i];
          line_hold[i] = $urandom_range(1, need);
        end else if (roll < 25) begin
          line_hold[i] = $urandom_range(1, need);
        end else begin
          line_level[i] = ~line_level[i];
          line_hold[i] = need + $urandom_range(0, need + 12);
        end
      end
      line_hold[i]--;
    end

    // Battery level holds for a while: below, above or anywhere.
    if (bat_hold <= 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) mv = $urandom_range(0, cur_low);
      else if (roll < 80) mv = $urandom_range(cur_low, MV_SCALE);
      else mv = $urandom_range(0, MV_SCALE);
      bat_base = (mv * ADC_FULL_SCALE) / MV_SCALE;
      bat_hold = $urandom_range(5, 80);
    end
    bat_hold--;
    bat = (bat_base >= ADC_FULL_SCALE) ? SAMPLE_W'(bat_base)
                                       : SAMPLE_W'(bat_base + $urandom_range(0, 1));
    if ($urandom_range(0, 19) == 0) bat = SAMPLE_W'($urandom);

    roll = $urandom_range(0, 9);
    if (roll == 0) bus = '0;
    else if (roll == 1) bus = '1;
    else bus = SAMPLE_W'($urandom);

    send_tick(bus, bat, line_level[0], line_level[NUM_BUTTONS:1]);
  endtask

  task run_phase(input int count, input bit pause_midway);
    for (int i = 0; i < count; i++) begin
      random_tick();
      if (pause_midway && i == count / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    int low;
    int cs;
    int bs;
    int blink;
    for (int i = 0; i <= NUM_BUTTONS; i++) line_hold[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sample extremes and pin levels under the reset register values.
    send_tick(12'd0, 12'd0, 1'b0, 3'b000);
    send_tick(12'd4095, 12'd4095, 1'b1, 3'b111);
    send_tick(12'd1, 12'd4094, 1'b0, 3'b101);
    send_tick(12'd4094, 12'd1, 1'b1, 3'b010);
    send_tick(12'd1266, 12'd1265, 1'b1, 3'b010);
    send_tick(12'd1267, 12'd1266, 1'b1, 3'b000);
    drain_results();

    // Immediate settling: LED lit, blinking every tick, dark, and every event.
    program_registers(MV_SCALE, 0, 0, 15, 0);
    send_tick(12'd100, 12'd0, 1'b0, 3'b000);
    send_tick(12'd200, 12'd0, 1'b1, 3'b111);
    send_tick(12'd300, 12'd0, 1'b1, 3'b111);
    send_tick(12'd400, 12'd0, 1'b1, 3'b111);
    send_tick(12'd500, 12'd4095, 1'b1, 3'b110);
    send_tick(12'd600, 12'd4095, 1'b1, 3'b110);
    send_tick(12'd0, 12'd4094, 1'b1, 3'b110);
    send_tick(12'd4095, 12'd4094, 1'b1, 3'b010);
    send_tick(12'd4095, 12'd4094, 1'b1, 3'b010);
    send_tick(12'd0, 12'd0, 1'b0, 3'b101);
    send_tick(12'd0, 12'd0, 1'b0, 3'b101);
    send_tick(12'd0, 12'd0, 1'b1, 3'b000);
    send_tick(12'd0, 12'd0, 1'b0, 3'b000);
    send_tick(12'd4095, 12'd4095, 1'b0, 3'b111);
    send_tick(12'd4095, 12'd4095, 1'b0, 3'b111);
    run_phase(150, 1'b0);

    // Slowest settling with the longest blink period and no low threshold.
    program_registers(0, 255, 255, 1, 1023);
    run_phase(350, 1'b0);

    // Zero step: the charger settles at once, the buttons never do.
    program_registers($urandom_range(0, MV_SCALE), 0, $urandom_range(1, 255), 0,
                      $urandom_range(0, 1023));
    run_phase(40, 1'b0);

    // Random register sets, mostly with short settling and blink periods.
    for (int p = 0; p < 4; p++) begin
      low = $urandom_range(0, 1) ? $urandom_range(2000, 5000) : $urandom_range(0, MV_SCALE);
      cs = $urandom_range(0, 1) ? $urandom_range(0, 60) : $urandom_range(0, 255);
      bs = $urandom_range(0, 1) ? $urandom_range(0, 60) : $urandom_range(0, 255);
      blink = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
      program_registers(low, cs, bs, $urandom_range(1, 15), blink);
      run_phase(110, p == 0);
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
